// ----- hdl/rau_pkg.sv -----
// Shared types, codes and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

  localparam int OperandWidth = 16;
  localparam int ResWidth     = 33;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    REL_LESS    = 2'd0,
    REL_EQUAL   = 2'd1,
    REL_GREATER = 2'd2
  } relation_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_DEN_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_REDUCE = 2'd0,
    KIND_DIRECT = 2'd1
  } kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GCD,
    BK_DIVN,
    BK_DIVD,
    BK_OUT
  } bk_state_t;

endpackage

// ----- hdl/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: front end forms products, back end reduces by gcd.
// Items that need no reduction (zero numerator, compare or a flagged operand)
// go straight to the output stage; the others pass through the binary gcd and
// the two divisions. The back end holds one item at a time; the front end can
// take the next item meanwhile. Depends on rau_pkg,
// rau_front, rau_back. Synchronous active-low reset clears all handshake and state control.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,  // left_num, left_den, right_num, right_den
  input  logic [2:0]   in_tuser,  // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata  // res_num, res_den, relation, status, zero pad
);
  localparam int RW = rau_pkg::ResWidth;
  logic q_valid, q_ready;
  logic [RW-1:0] q_num, q_den, r_num, r_den;
  logic [1:0] q_kind, q_rel, q_status, rel, st;

  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .op(in_tuser),
    .a_in(in_tdata[15:0]), .b_in(in_tdata[31:16]), .c_in(in_tdata[47:32]),
    .d_in(in_tdata[63:48]), .q_valid, .q_ready, .q_num, .q_den, .q_kind,
    .q_rel, .q_status
  );

  rau_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_num, .q_den, .q_kind, .q_rel, .q_status,
    .out_valid(out_tvalid), .out_ready(out_tready), .res_num(r_num),
    .res_den(r_den), .relation(rel), .status(st)
  );

  assign out_tdata = {2'b0, st, rel, r_den, r_num};
endmodule

// ----- hdl/rau_front.sv -----
// Front end: multiplies the cross products in steps on two multipliers and classifies the item.
// Depends on rau_pkg.
module rau_front #(
  parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [15:0] a_in,
  input  logic [15:0] b_in,
  input  logic [15:0] c_in,
  input  logic [15:0] d_in,
  output logic        q_valid,
  input  logic        q_ready,
  output logic [rau_pkg::ResWidth-1:0] q_num,
  output logic [rau_pkg::ResWidth-1:0] q_den,
  output logic [1:0]  q_kind,
  output logic [1:0]  q_rel,
  output logic [1:0]  q_status
);
  localparam int W = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int RW = rau_pkg::ResWidth;

  logic signed [W-1:0] a_r, b_r, c_r, d_r;
  logic [2:0] op_r;
  logic [1:0] step_r;
  logic busy_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r;
  logic signed [PW-1:0] m_x, m_y;
  logic signed [W-1:0] mx_a, mx_b, my_a, my_b;
  logic signed [SW-1:0] sum, n_full;
  logic signed [SW-1:0] den_full;
  logic [1:0] kind_nxt, rel_nxt, st_nxt;
  logic [RW-1:0] num_nxt, den_nxt;

  assign in_ready = !busy_r;

  always_comb begin
    mx_a = a_r; mx_b = d_r; my_a = b_r; my_b = c_r;
    case (step_r)
      2'd0: begin
        mx_a = a_r; mx_b = d_r; my_a = b_r; my_b = c_r;
      end
      2'd1: begin
        mx_a = a_r; mx_b = c_r; my_a = b_r; my_b = d_r;
      end
      default: begin
        mx_a = b_r; mx_b = c_r; my_a = b_r; my_b = d_r;
      end
    endcase
    m_x = mx_a * mx_b;
    m_y = my_a * my_b;
  end

  always_comb begin
    sum = '0; n_full = '0; den_full = SW'(p3_r);
    case (op_r)
      rau_pkg::OP_ADD: n_full = SW'(p1_r) + SW'(p2_r);
      rau_pkg::OP_SUB: n_full = SW'(p1_r) - SW'(p2_r);
      rau_pkg::OP_MUL: n_full = SW'(p1_r);
      rau_pkg::OP_DIV: begin
        n_full = SW'(p1_r);
        den_full = SW'(p2_r);
      end
      default: sum = SW'(p1_r) - SW'(p2_r);
    endcase
  end

  always_comb begin
    kind_nxt = rau_pkg::KIND_REDUCE;
    rel_nxt = rau_pkg::REL_EQUAL;
    st_nxt = rau_pkg::ST_OK;
    num_nxt = RW'(n_full);
    den_nxt = RW'(den_full);
    if (b_r == '0 || d_r == '0) begin
      kind_nxt = rau_pkg::KIND_DIRECT;
      st_nxt = rau_pkg::ST_DEN_ZERO;
      num_nxt = '0; den_nxt = '0;
    end else if (op_r == rau_pkg::OP_DIV && c_r == '0) begin
      kind_nxt = rau_pkg::KIND_DIRECT;
      st_nxt = rau_pkg::ST_DIV_ZERO;
      num_nxt = '0; den_nxt = '0;
    end else if (op_r > rau_pkg::OP_DIV) begin
      kind_nxt = rau_pkg::KIND_DIRECT;
      num_nxt = '0; den_nxt = '0;
      if (sum != '0) begin
        rel_nxt = ((sum[SW-1]) ^ (b_r[W-1] ^ d_r[W-1])) ? rau_pkg::REL_LESS
                                                        : rau_pkg::REL_GREATER;
      end
    end else if (n_full == '0) begin
      kind_nxt = rau_pkg::KIND_DIRECT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      q_valid <= 1'b0;
    end else begin
      if (q_valid && q_ready) q_valid <= 1'b0;
      if (!busy_r && in_valid) begin
        busy_r <= 1'b1;
        step_r <= '0;
        op_r <= op;
        a_r <= a_in[W-1:0]; b_r <= b_in[W-1:0];
        c_r <= c_in[W-1:0]; d_r <= d_in[W-1:0];
      end else if (busy_r && step_r == 2'd0) begin
        p1_r <= m_x; p2_r <= m_y;
        if (op_r == rau_pkg::OP_MUL || op_r == rau_pkg::OP_DIV) begin
          step_r <= 2'd1;
        end else begin
          step_r <= 2'd2;
        end
      end else if (busy_r && step_r == 2'd1) begin
        if (op_r == rau_pkg::OP_MUL) begin
          p1_r <= m_x; p3_r <= m_y;
        end
        step_r <= 2'd3;
      end else if (busy_r && step_r == 2'd2) begin
        p3_r <= m_y;
        step_r <= 2'd3;
      end else if (busy_r && step_r == 2'd3 && !q_valid) begin
        busy_r <= 1'b0;
        q_valid <= 1'b1;
        q_kind <= kind_nxt;
        q_rel <= rel_nxt;
        q_status <= st_nxt;
        q_num <= num_nxt;
        q_den <= den_nxt;
      end
    end
  end
endmodule

// ----- hdl/rau_back.sv -----
// Back end: reduces a fraction by the gcd of its magnitudes (binary gcd and
// restoring division) and fixes the sign. Depends on rau_pkg.
module rau_back (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  logic [rau_pkg::ResWidth-1:0] q_num,
  input  logic [rau_pkg::ResWidth-1:0] q_den,
  input  logic [1:0]  q_kind,
  input  logic [1:0]  q_rel,
  input  logic [1:0]  q_status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [rau_pkg::ResWidth-1:0] res_num,
  output logic [rau_pkg::ResWidth-1:0] res_den,
  output logic [1:0]  relation,
  output logic [1:0]  status
);
  localparam int RW = rau_pkg::ResWidth;
  localparam int MW = RW + 1;
  localparam int CW = $clog2(MW + 1);

  rau_pkg::bk_state_t state_r, state_nxt;
  logic [RW-1:0] num_r, den_r;
  logic [1:0] rel_r, st_r;
  logic [MW-1:0] x_r, y_r, g_r;
  logic [CW-1:0] sh_r, cnt_r;
  logic [MW-1:0] quo_r, rem_r, dv_r;
  logic [MW-1:0] mn, md, rem_sh, xd, yd;
  logic sgn_n_r, sgn_d_r;
  logic [RW-1:0] qn_r, qd_r;
  logic [MW-1:0] trial;

  assign mn = q_num[RW-1] ? MW'(-$signed({q_num[RW-1], q_num})) : MW'(q_num);
  assign md = q_den[RW-1] ? MW'(-$signed({q_den[RW-1], q_den})) : MW'(q_den);
  assign rem_sh = {rem_r[MW-2:0], quo_r[MW-1]};
  assign trial = rem_sh - dv_r;
  assign xd = (x_r > y_r) ? x_r - y_r : y_r - x_r;
  assign yd = (x_r > y_r) ? y_r : x_r;
  assign q_ready = (state_r == rau_pkg::BK_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rau_pkg::BK_IDLE: if (q_valid) begin
        state_nxt = (q_kind == rau_pkg::KIND_DIRECT) ? rau_pkg::BK_OUT : rau_pkg::BK_GCD;
      end
      rau_pkg::BK_GCD: if (y_r == '0 || x_r == y_r) state_nxt = rau_pkg::BK_DIVN;
      rau_pkg::BK_DIVN: if (cnt_r == CW'(MW)) state_nxt = rau_pkg::BK_DIVD;
      rau_pkg::BK_DIVD: if (cnt_r == CW'(MW)) state_nxt = rau_pkg::BK_OUT;
      rau_pkg::BK_OUT: if (!out_valid || out_ready) state_nxt = rau_pkg::BK_IDLE;
      default: state_nxt = rau_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rau_pkg::BK_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        rau_pkg::BK_IDLE: if (q_valid) begin
          num_r <= q_num; den_r <= q_den; rel_r <= q_rel; st_r <= q_status;
          sgn_n_r <= q_num[RW-1]; sgn_d_r <= q_den[RW-1];
          x_r <= mn; y_r <= md; sh_r <= '0;
        end
        rau_pkg::BK_GCD: begin
          if (y_r == '0 || x_r == y_r) begin
            g_r <= x_r << sh_r;
            dv_r <= x_r << sh_r;
            quo_r <= {1'b0, num_r[RW-1] ? RW'(-num_r) : num_r};
            rem_r <= '0; cnt_r <= '0;
          end else if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1; y_r <= y_r >> 1; sh_r <= sh_r + 1'b1;
          end else if (!x_r[0]) x_r <= x_r >> 1;
          else if (!y_r[0]) y_r <= y_r >> 1;
          else begin
            x_r <= xd >> 1; y_r <= yd;
          end
        end
        rau_pkg::BK_DIVN, rau_pkg::BK_DIVD: begin
          if (cnt_r == CW'(MW)) begin
            if (state_r == rau_pkg::BK_DIVN) begin
              qn_r <= RW'(quo_r);
              quo_r <= {1'b0, den_r[RW-1] ? RW'(-den_r) : den_r};
              rem_r <= '0; cnt_r <= '0;
            end else qd_r <= RW'(quo_r);
          end else begin
            cnt_r <= cnt_r + 1'b1;
            if (!trial[MW-1] && rem_sh >= dv_r) begin
              rem_r <= trial; quo_r <= {quo_r[MW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh; quo_r <= {quo_r[MW-2:0], 1'b0};
            end
          end
        end
        rau_pkg::BK_OUT: if (!out_valid || out_ready) begin
          relation <= rel_r; status <= st_r;
          if (g_r == '0 || st_r != rau_pkg::ST_OK || num_r == '0
              || rel_r != rau_pkg::REL_EQUAL) begin
            res_num <= num_r; res_den <= den_r;
          end else begin
            res_num <= (sgn_n_r ^ sgn_d_r) ? RW'(-qn_r) : qn_r;
            res_den <= qd_r;
          end
        end
        default: ;
      endcase
      if (state_r == rau_pkg::BK_IDLE && q_valid && q_kind == rau_pkg::KIND_DIRECT)
        g_r <= '0;
    end
  end
endmodule

// ----- tb/sv/tb_rational_arithmetic_unit.sv -----
// Testbench for rational_arithmetic_unit: drives fraction operations on the
// input stream and checks each result beat against an in-bench predictor.
// Depends on rau_pkg and the unit's RTL.
module tb_rational_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  st;
    logic [1:0]  rel;
    logic [32:0] den;
    logic [32:0] num;
  } frac_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  frac_result_t expected_q[$];
  int  mismatches = 0;
  int  sent = 0;
  bit  hold_off = 1'b0;

  rational_arithmetic_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint gcd_of(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_result_t predict_fraction(logic [2:0] op, logic signed [15:0] ln,
      logic signed [15:0] ld, logic signed [15:0] rn, logic signed [15:0] rd);
    longint a, b, c, d, n, m, g, diff;
    frac_result_t r;
    a = ln; b = ld; c = rn; d = rd;
    n = 0; m = 0;
    r.rel = rau_pkg::REL_EQUAL;
    r.st = rau_pkg::ST_OK;
    if (b == 0 || d == 0) begin
      r.st = rau_pkg::ST_DEN_ZERO;
    end else if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB || op == rau_pkg::OP_MUL ||
                 (op == rau_pkg::OP_DIV && c != 0)) begin
      case (op)
        rau_pkg::OP_ADD: begin n = a * d + b * c; m = b * d; end
        rau_pkg::OP_SUB: begin n = a * d - b * c; m = b * d; end
        rau_pkg::OP_MUL: begin n = a * c; m = b * d; end
        default: begin n = a * d; m = b * c; end
      endcase
      if (n != 0) begin
        g = gcd_of(n < 0 ? -n : n, m < 0 ? -m : m);
        if (g > 1) begin
          n = n / g;
          m = m / g;
        end
        if (m < 0) begin
          n = -n;
          m = -m;
        end
      end
    end else if (op == rau_pkg::OP_DIV) begin
      r.st = rau_pkg::ST_DIV_ZERO;
    end else begin
      diff = a * d - c * b;
      if ((b < 0) != (d < 0)) diff = -diff;
      r.rel = diff > 0 ? rau_pkg::REL_GREATER :
              (diff < 0 ? rau_pkg::REL_LESS : rau_pkg::REL_EQUAL);
    end
    r.num = n[32:0];
    r.den = m[32:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [32:0] got, logic [32:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  task automatic send_fraction(logic [2:0] op, logic [15:0] ln, logic [15:0] ld,
      logic [15:0] rn, logic [15:0] rd);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {rd, rn, ld, ln};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_fraction(op, ln, ld, rn, rd));
    sent++;
    if ($urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(16)) - 8);
      3: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] rand_opcode();
    return $urandom_range(9) == 0 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
  endfunction

  task automatic test_directed();
    logic [2:0] op;
    for (int k = 0; k < 5; k++) begin
      op = 3'(k);
      send_fraction(op, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      send_fraction(op, 16'd6, 16'd4, 16'hfffd, 16'hfffe);
      send_fraction(op, 16'd0, 16'hffff, 16'd1, 16'd3);
    end
    send_fraction(rau_pkg::OP_DIV, 16'd5, 16'd7, 16'd0, 16'd2);
    send_fraction(rau_pkg::OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1);
    send_fraction(rau_pkg::OP_DIV, 16'd1, 16'd1, 16'd0, 16'd0);
    send_fraction(rau_pkg::OP_CMP, 16'd1, 16'd2, 16'd2, 16'd4);
    send_fraction(3'd5, 16'd1, 16'd2, 16'd1, 16'd3);
    send_fraction(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fraction(rau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
  endtask

  task automatic test_random();
    logic [15:0] rd, ld;
    for (int i = 0; i < 1000; i++) begin
      ld = rand_operand();
      rd = rand_operand();
      if ($urandom_range(30) != 0) begin
        if (ld == 0) ld = 16'd1;
        if (rd == 0) rd = 16'hffff;
      end
      send_fraction(rand_opcode(), rand_operand(), ld, rand_operand(), rd);
    end
  endtask

  task automatic test_backpressure();
    for (int i = 0; i < 30; i++)
      send_fraction(rand_opcode(), rand_operand(), 16'd3, rand_operand(), 16'hfffb);
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(7) != 0) || (sent % 200 < 50);
    end
  end

  always @(posedge clk) begin
    frac_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[69:0];
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", got.num, '0);
      end else begin
        want = expected_q.pop_front();
        if (got.num !== want.num) report_mismatch("res_num", got.num, want.num);
        if (got.den !== want.den) report_mismatch("res_den", got.den, want.den);
        if (got.rel !== want.rel) report_mismatch("relation", 33'(got.rel), 33'(want.rel));
        if (got.st !== want.st) report_mismatch("status", 33'(got.st), 33'(want.st));
      end
    end
  end

  initial begin
    #50_000_000;
    $display("tb_rational_arithmetic_unit: FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    fork
      test_backpressure();
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_rational_arithmetic_unit: PASS");
    end else begin
      $display("tb_rational_arithmetic_unit: FAIL");
    end
    $finish;
  end
endmodule
